[design/arpc_pkg.sv]
`default_nettype none

package arpc_pkg;

    // Operation codes carried by i_op
    typedef enum logic [2:0] {
        OP_LOOKUP = 3'd0,
        OP_INSERT = 3'd1,
        OP_QUEUE  = 3'd2,
        OP_REMOVE = 3'd3,
        OP_TICK   = 3'd4,
        OP_CLEAR  = 3'd5
    } t_op;

    // Result status codes
    typedef enum logic [3:0] {
        ST_MISS      = 4'd0,
        ST_HIT       = 4'd1,
        ST_INSERTED  = 4'd2,
        ST_FULL      = 4'd3,
        ST_QUEUED    = 4'd4,
        ST_EXISTS    = 4'd5,
        ST_REQ_FULL  = 4'd6,
        ST_REMOVED   = 4'd7,
        ST_ABSENT    = 4'd8,
        ST_SEND      = 4'd9,
        ST_DROPPED   = 4'd10,
        ST_TICK_DONE = 4'd11,
        ST_CLEARED   = 4'd12
    } t_status;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TIMEOUT   = 2'd0,
        CFG_MAX_SENDS = 2'd1
    } t_cfg_idx;

    localparam logic [15:0] TIMEOUT_RST   = 16'd30;
    localparam logic [3:0]  MAX_SENDS_RST = 4'd5;
    localparam logic [15:0] AGE_MAX       = 16'hFFFF;

    // Cache entry as stored in the entry RAM
    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [15:0] age;
    } t_entry;

    // Pending request as stored in the request RAM
    typedef struct packed {
        logic [31:0] ip;
        logic [3:0]  sends;
    } t_req;

    // One result transaction
    typedef struct packed {
        t_status     status;
        logic [31:0] target_ip;
        logic [47:0] found_mac;
        logic        pending_found;
        logic        last;
    } t_result;

    // Shared compare unit outputs
    typedef struct packed {
        logic        ip_eq;
        logic [15:0] age_next;
        logic        age_keep;
        logic        send_drop;
        logic [3:0]  sends_next;
    } t_alu_res;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_L_RD,
        S_L_CMP,
        S_F_RD,
        S_F_CMP,
        S_F_END,
        S_SH_RD,
        S_SH_WR,
        S_T_RD,
        S_T_CMP,
        S_W_RD,
        S_W_CMP,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

[design/arpc_ram.sv]
`default_nettype none

// Simple dual-port RAM: one write port, one registered read port
module arpc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2,
    parameter int unsigned AW    = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[design/arpc_alu.sv]
`default_nettype none

// Shared compare unit: IP match, saturating age step against the timeout,
// send count check against max_sends
module arpc_alu (
    input  wire logic [31:0]       i_key,
    input  wire logic [31:0]       i_cand_ip,
    input  wire logic [15:0]       i_age,
    input  wire logic [15:0]       i_timeout,
    input  wire logic [3:0]        i_sends,
    input  wire logic [3:0]        i_max_sends,
    output arpc_pkg::t_alu_res     o_res
);

    logic [15:0] age_next;

    // saturating age increment
    assign age_next = (i_age == arpc_pkg::AGE_MAX) ? i_age : i_age + 16'd1;

    always_comb begin
        o_res.ip_eq      = (i_key == i_cand_ip);
        o_res.age_next   = age_next;
        o_res.age_keep   = (age_next <= i_timeout);
        o_res.send_drop  = (i_sends >= i_max_sends);
        o_res.sends_next = i_sends + 4'd1;
    end

endmodule

`default_nettype wire

[design/arp_cache_with_aging_and_retry.sv]
`default_nettype none

// ARP cache with aging and request retry; one operation at a time, not ready while busy.
// Clear empties both lists at once; lookup scans entries oldest first and stops on a hit;
// insert/queue/remove scan the pending requests and stop when found, and a found remove then
// shifts the later requests down; tick ages every entry, then walks the requests and shifts
// them down on a drop. The sequencer waits while the result register is held.
// Synchronous active-low reset empties both lists and loads timeout 30, max_sends 5.
module arp_cache_with_aging_and_retry #(
    parameter int unsigned CACHE_ENTRIES    = 32,
    parameter int unsigned PENDING_REQUESTS = 8
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // operation channel
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [2:0]                      i_op,
    input  wire logic [31:0]                     i_ip,
    input  wire logic [47:0]                     i_mac,
    // result channel
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [3:0]                           o_status,
    output logic [31:0]                          o_target_ip,
    output logic [47:0]                          o_found_mac,
    output logic                                 o_pending_found,
    output logic                                 o_last,
    // configuration channel
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [arpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [arpc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned EA_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int unsigned EC_W = $clog2(CACHE_ENTRIES + 1);
    localparam int unsigned RA_W = (PENDING_REQUESTS > 1) ? $clog2(PENDING_REQUESTS) : 1;
    localparam int unsigned RC_W = $clog2(PENDING_REQUESTS + 1);
    localparam int unsigned EW   = $bits(arpc_pkg::t_entry);
    localparam int unsigned RW   = $bits(arpc_pkg::t_req);
    localparam logic [EC_W-1:0] E_FULL = EC_W'(CACHE_ENTRIES);
    localparam logic [RC_W-1:0] R_FULL = RC_W'(PENDING_REQUESTS);

    // sequencer registers
    arpc_pkg::t_state  r_state, n_state;
    arpc_pkg::t_state  r_ret, n_ret;
    arpc_pkg::t_op     r_op, n_op;
    logic [31:0]       r_ip, n_ip;
    logic [47:0]       r_mac, n_mac;
    logic              r_hit, n_hit;
    logic [EC_W-1:0]   r_ecnt, n_ecnt;
    logic [EC_W-1:0]   r_eidx, n_eidx;
    logic [EC_W-1:0]   r_ewr, n_ewr;
    logic [RC_W-1:0]   r_rcnt, n_rcnt;
    logic [RC_W-1:0]   r_ridx, n_ridx;
    arpc_pkg::t_result r_res, n_res;
    arpc_pkg::t_result r_out, n_out;
    logic              r_out_vld, n_out_vld;
    logic [15:0]       r_timeout;
    logic [3:0]        r_max_sends;

    // RAM ports
    logic              ent_we;
    logic [EA_W-1:0]   ent_waddr, ent_raddr;
    arpc_pkg::t_entry  ent_wdata, ent_rdata;
    logic [EW-1:0]     ent_rbits;
    logic              req_we;
    logic [RA_W-1:0]   req_waddr, req_raddr;
    arpc_pkg::t_req    req_wdata, req_rdata;
    logic [RW-1:0]     req_rbits;

    // compare unit
    logic [31:0]        alu_cand_ip;
    arpc_pkg::t_alu_res alu;

    logic              out_free;
    logic [RC_W-1:0]   ridx_inc;

    assign ent_rdata = arpc_pkg::t_entry'(ent_rbits);
    assign req_rdata = arpc_pkg::t_req'(req_rbits);

    arpc_ram #(
        .WIDTH (EW),
        .DEPTH (CACHE_ENTRIES),
        .AW    (EA_W)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (ent_waddr),
        .i_wdata (EW'(ent_wdata)),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rbits)
    );

    arpc_ram #(
        .WIDTH (RW),
        .DEPTH (PENDING_REQUESTS),
        .AW    (RA_W)
    ) u_req_ram (
        .i_clk   (i_clk),
        .i_we    (req_we),
        .i_waddr (req_waddr),
        .i_wdata (RW'(req_wdata)),
        .i_raddr (req_raddr),
        .o_rdata (req_rbits)
    );

    // entry IP in lookup, request IP elsewhere
    assign alu_cand_ip = (r_state == arpc_pkg::S_L_CMP) ? ent_rdata.ip : req_rdata.ip;

    arpc_alu u_alu (
        .i_key       (r_ip),
        .i_cand_ip   (alu_cand_ip),
        .i_age       (ent_rdata.age),
        .i_timeout   (r_timeout),
        .i_sends     (req_rdata.sends),
        .i_max_sends (r_max_sends),
        .o_res       (alu)
    );

    assign out_free    = !r_out_vld || i_ready;
    assign ridx_inc    = r_ridx + RC_W'(1);
    assign o_ready     = (r_state == arpc_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;

    // result register outputs
    assign o_valid         = r_out_vld;
    assign o_status        = r_out.status;
    assign o_target_ip     = r_out.target_ip;
    assign o_found_mac     = r_out.found_mac;
    assign o_pending_found = r_out.pending_found;
    assign o_last          = r_out.last;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= arpc_pkg::TIMEOUT_RST;
            r_max_sends <= arpc_pkg::MAX_SENDS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                arpc_pkg::CFG_TIMEOUT:   r_timeout   <= i_cfg_data;
                arpc_pkg::CFG_MAX_SENDS: r_max_sends <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= arpc_pkg::S_IDLE;
            r_ret     <= arpc_pkg::S_IDLE;
            r_ecnt    <= '0;
            r_rcnt    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_ecnt    <= n_ecnt;
            r_rcnt    <= n_rcnt;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_ip   <= n_ip;
        r_mac  <= n_mac;
        r_hit  <= n_hit;
        r_eidx <= n_eidx;
        r_ewr  <= n_ewr;
        r_ridx <= n_ridx;
        r_res  <= n_res;
        r_out  <= n_out;
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_ret     = r_ret;
        n_op      = r_op;
        n_ip      = r_ip;
        n_mac     = r_mac;
        n_hit     = r_hit;
        n_ecnt    = r_ecnt;
        n_eidx    = r_eidx;
        n_ewr     = r_ewr;
        n_rcnt    = r_rcnt;
        n_ridx    = r_ridx;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld && !i_ready;

        ent_we    = 1'b0;
        ent_waddr = r_ewr[EA_W-1:0];
        ent_wdata = '0;
        ent_raddr = r_eidx[EA_W-1:0];
        req_we    = 1'b0;
        req_waddr = r_ridx[RA_W-1:0];
        req_wdata = '0;
        req_raddr = r_ridx[RA_W-1:0];

        unique case (r_state)
            arpc_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_op   = arpc_pkg::t_op'(i_op);
                    n_ip   = i_ip;
                    n_mac  = i_mac;
                    n_hit  = 1'b0;
                    n_eidx = '0;
                    n_ewr  = '0;
                    n_ridx = '0;
                    n_ret  = arpc_pkg::S_IDLE;
                    case (arpc_pkg::t_op'(i_op))
                        arpc_pkg::OP_LOOKUP: n_state = arpc_pkg::S_L_RD;
                        arpc_pkg::OP_INSERT,
                        arpc_pkg::OP_QUEUE,
                        arpc_pkg::OP_REMOVE: n_state = arpc_pkg::S_F_RD;
                        arpc_pkg::OP_TICK:   n_state = arpc_pkg::S_T_RD;
                        arpc_pkg::OP_CLEAR: begin
                            n_ecnt  = '0;
                            n_rcnt  = '0;
                            n_res   = '{arpc_pkg::ST_CLEARED, 32'd0, 48'd0, 1'b0, 1'b1};
                            n_state = arpc_pkg::S_EMIT;
                        end
                        default: ;
                    endcase
                end
            end

            // lookup: scan entries oldest first
            arpc_pkg::S_L_RD: begin
                if (r_eidx == r_ecnt) begin
                    n_res   = '{arpc_pkg::ST_MISS, r_ip, 48'd0, 1'b0, 1'b1};
                    n_state = arpc_pkg::S_EMIT;
                end else begin
                    n_state = arpc_pkg::S_L_CMP;
                end
            end
            arpc_pkg::S_L_CMP: begin
                if (alu.ip_eq) begin
                    n_res   = '{arpc_pkg::ST_HIT, r_ip, ent_rdata.mac, 1'b0, 1'b1};
                    n_state = arpc_pkg::S_EMIT;
                end else begin
                    n_eidx  = r_eidx + EC_W'(1);
                    n_state = arpc_pkg::S_L_RD;
                end
            end

            // pending request search
            arpc_pkg::S_F_RD: begin
                if (r_ridx == r_rcnt) begin
                    n_state = arpc_pkg::S_F_END;
                end else begin
                    n_state = arpc_pkg::S_F_CMP;
                end
            end
            arpc_pkg::S_F_CMP: begin
                if (alu.ip_eq) begin
                    n_hit   = 1'b1;
                    n_state = arpc_pkg::S_F_END;
                end else begin
                    n_ridx  = ridx_inc;
                    n_state = arpc_pkg::S_F_RD;
                end
            end
            arpc_pkg::S_F_END: begin
                n_state = arpc_pkg::S_EMIT;
                case (r_op)
                    arpc_pkg::OP_INSERT: begin
                        if (r_ecnt != E_FULL) begin
                            ent_we    = 1'b1;
                            ent_waddr = r_ecnt[EA_W-1:0];
                            ent_wdata = '{r_ip, r_mac, 16'd0};
                            n_ecnt    = r_ecnt + EC_W'(1);
                            n_res     = '{arpc_pkg::ST_INSERTED, r_ip, 48'd0, r_hit, 1'b1};
                        end else begin
                            n_res     = '{arpc_pkg::ST_FULL, r_ip, 48'd0, r_hit, 1'b1};
                        end
                    end
                    arpc_pkg::OP_QUEUE: begin
                        if (r_hit) begin
                            n_res     = '{arpc_pkg::ST_EXISTS, r_ip, 48'd0, 1'b0, 1'b1};
                        end else if (r_rcnt != R_FULL) begin
                            req_we    = 1'b1;
                            req_waddr = r_rcnt[RA_W-1:0];
                            req_wdata = '{r_ip, 4'd0};
                            n_rcnt    = r_rcnt + RC_W'(1);
                            n_res     = '{arpc_pkg::ST_QUEUED, r_ip, 48'd0, 1'b0, 1'b1};
                        end else begin
                            n_res     = '{arpc_pkg::ST_REQ_FULL, r_ip, 48'd0, 1'b0, 1'b1};
                        end
                    end
                    default: begin
                        // remove: close the gap when found
                        if (r_hit) begin
                            n_state = arpc_pkg::S_SH_RD;
                        end else begin
                            n_res   = '{arpc_pkg::ST_ABSENT, r_ip, 48'd0, 1'b0, 1'b1};
                        end
                    end
                endcase
            end

            // shift requests above r_ridx down by one
            arpc_pkg::S_SH_RD: begin
                req_raddr = ridx_inc[RA_W-1:0];
                if (ridx_inc == r_rcnt) begin
                    n_rcnt  = r_rcnt - RC_W'(1);
                    n_ret   = arpc_pkg::S_IDLE;
                    n_state = arpc_pkg::S_EMIT;
                    if (r_op == arpc_pkg::OP_TICK) begin
                        n_res = '{arpc_pkg::ST_TICK_DONE, 32'd0, 48'd0, 1'b0, 1'b1};
                    end else begin
                        n_res = '{arpc_pkg::ST_REMOVED, r_ip, 48'd0, 1'b0, 1'b1};
                    end
                end else begin
                    n_state = arpc_pkg::S_SH_WR;
                end
            end
            arpc_pkg::S_SH_WR: begin
                req_we    = 1'b1;
                req_wdata = req_rdata;
                n_ridx    = ridx_inc;
                n_state   = arpc_pkg::S_SH_RD;
            end

            // tick: age entries and compact survivors
            arpc_pkg::S_T_RD: begin
                if (r_eidx == r_ecnt) begin
                    n_ecnt  = r_ewr;
                    n_ridx  = '0;
                    n_state = arpc_pkg::S_W_RD;
                end else begin
                    n_state = arpc_pkg::S_T_CMP;
                end
            end
            arpc_pkg::S_T_CMP: begin
                if (alu.age_keep) begin
                    ent_we    = 1'b1;
                    ent_wdata = '{ent_rdata.ip, ent_rdata.mac, alu.age_next};
                    n_ewr     = r_ewr + EC_W'(1);
                end
                n_eidx  = r_eidx + EC_W'(1);
                n_state = arpc_pkg::S_T_RD;
            end

            // tick: walk pending requests
            arpc_pkg::S_W_RD: begin
                if (r_ridx == r_rcnt) begin
                    n_res   = '{arpc_pkg::ST_TICK_DONE, 32'd0, 48'd0, 1'b0, 1'b1};
                    n_ret   = arpc_pkg::S_IDLE;
                    n_state = arpc_pkg::S_EMIT;
                end else begin
                    n_state = arpc_pkg::S_W_CMP;
                end
            end
            arpc_pkg::S_W_CMP: begin
                n_state = arpc_pkg::S_EMIT;
                if (alu.send_drop) begin
                    n_res = '{arpc_pkg::ST_DROPPED, req_rdata.ip, 48'd0, 1'b0, 1'b0};
                    n_ret = arpc_pkg::S_SH_RD;
                end else begin
                    req_we    = 1'b1;
                    req_wdata = '{req_rdata.ip, alu.sends_next};
                    n_ridx    = ridx_inc;
                    n_res     = '{arpc_pkg::ST_SEND, req_rdata.ip, 48'd0, 1'b0, 1'b0};
                    n_ret     = arpc_pkg::S_W_RD;
                end
            end

            // hand one result to the output register
            arpc_pkg::S_EMIT: begin
                if (out_free) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = r_ret;
                end
            end

            default: n_state = arpc_pkg::S_IDLE;
        endcase
    end

endmodule

`default_nettype wire
